@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module jet_checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define JET_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked through reset as well.
`define JET_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/jet_pkg.sv @@
// Types, constants and helpers for the Julia escape-time pixel block.
// Used by every module in rtl/core; depends on nothing.
package jet_pkg;

   localparam int ROWS     = 1024;
   localparam int COLS     = 1024;
   localparam int POS_W    = 10;
   localparam int Q_W      = 32;
   localparam int FRAC     = 28;
   localparam int LIM_W    = 16;
   localparam int BRIGHT_W = 16;
   localparam int T_W      = LIM_W + 1;
   localparam int MUL_W    = 33;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ESC_SHIFT = 2 * FRAC + 2;
   localparam int COLOR_W  = 8;
   localparam int CSR_W    = 3;
   localparam int DIV_CNT_W = $clog2(T_W + 1);

   localparam logic [T_W-1:0] T_ONE = T_W'(1) << LIM_W;
   localparam logic [15:0] K_RED   = 16'd2295;
   localparam logic [15:0] K_GREEN = 16'd3825;
   localparam logic [15:0] K_BLUE  = 16'd4335;

   localparam logic signed [PROD_W-1:0] ROWS_DIV = PROD_W'(ROWS);
   localparam logic signed [PROD_W-1:0] COLS_DIV = PROD_W'(COLS);
   localparam logic signed [PROD_W-1:0] Q_MAX =
      {{(PROD_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] Q_MIN = ~Q_MAX;

   localparam logic [LIM_W-1:0]    RST_LIMIT  = 16'd256;
   localparam logic [Q_W-1:0]      RST_HALF   = 32'd402653184;
   localparam logic [BRIGHT_W-1:0] RST_BRIGHT = 16'd4096;

   typedef struct packed {
      logic [POS_W-1:0] pixel_row;
      logic [POS_W-1:0] pixel_col;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [LIM_W-1:0]   escape_count;
   } rsp_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_ITERATION_LIMIT  = 3'd0,
      CSR_VIEW_HALF_WIDTH  = 3'd1,
      CSR_VIEW_HALF_HEIGHT = 3'd2,
      CSR_C_REAL           = 3'd3,
      CSR_C_IMAG           = 3'd4,
      CSR_BRIGHTNESS       = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_X,
      ST_MAP_Y,
      ST_MAP_DONE,
      ST_IT_XX,
      ST_IT_YY,
      ST_IT_XY,
      ST_IT_UPD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_COLOR,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      CS_TT,
      CS_UU,
      CS_T2T,
      CS_T3U,
      CS_RK,
      CS_RB,
      CS_U2T2,
      CS_GK,
      CS_GB,
      CS_U2U,
      CS_U3T,
      CS_BK,
      CS_BB,
      CS_BLUE
   } color_step_type;

   typedef struct packed {
      logic             start;
      logic [LIM_W-1:0] dividend;
      logic [LIM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic           done;
      logic [T_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v > Q_MAX) begin
         r = Q_MAX[Q_W-1:0];
      end else if (v < Q_MIN) begin
         r = Q_MIN[Q_W-1:0];
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/jet_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on jet_pkg.
module jet_mul (
   input  logic                                clock,
   input  logic signed [jet_pkg::MUL_W-1:0]    mul_a,
   input  logic signed [jet_pkg::MUL_W-1:0]    mul_b,
   output logic signed [jet_pkg::PROD_W-1:0]   mul_prod
);
   import jet_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in  = mul_a * mul_b;
   assign mul_prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ rtl/core/jet_div.sv @@
// Radix-2 restoring divider: quotient of (dividend << 16) / divisor.
// Dividend must not exceed divisor. Depends on jet_pkg.
module jet_div (
   input  logic                  clock,
   input  logic                  reset,
   input  jet_pkg::div_req_type  div_req,
   output jet_pkg::div_rsp_type  div_rsp
);
   import jet_pkg::*;

   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(T_W);
   localparam logic [DIV_CNT_W-1:0] CNT_LAST  = DIV_CNT_W'(1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [LIM_W:0]       rem_ff, rem_in;
   logic [T_W-1:0]       quot_ff, quot_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 ge;
   logic [LIM_W:0]       rem_diff;
   logic [LIM_W-1:0]     rem_keep;

   assign ge       = rem_ff >= {1'b0, div_req.divisor};
   assign rem_diff = rem_ff - {1'b0, div_req.divisor};
   assign rem_keep = ge ? rem_diff[LIM_W-1:0] : rem_ff[LIM_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         rem_in  = {1'b0, div_req.dividend};
         quot_in = '0;
         cnt_in  = DIV_STEPS;
      end else if (busy_ff) begin
         quot_in = {quot_ff[T_W-2:0], ge};
         rem_in  = {rem_keep, 1'b0};
         cnt_in  = cnt_ff - CNT_LAST;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

@@ rtl/core/julia_escape_time_pixel.sv @@
// Julia escape-time pixel: one pixel position in, one coloured result out.
// Depends on jet_pkg, jet_mul and jet_div.
//
// Usage:
//   req_*  : pixel row and column; a word is taken when req_valid is high and
//            req_stall low. req_stall stays high from the accepted word until
//            its result word has been taken, so one pixel is in flight.
//   rsp_*  : red, green, blue and escape_count; the word is held in registers
//            and stays unchanged while rsp_stall is high.
//   csr_*  : register writes, always ready; write only while no pixel is in
//            flight. Index 0..5: limit, half width, half height, c real,
//            c imaginary, brightness. Other indexes are dropped.
// Flow: from accept to result a pixel passes the mapping states, the
//   iteration loop, the divider (skipped with a zero limit) and the colour steps,
//   then waits while rsp_stall is high. The one 33x33 multiplier is shared by the
//   mapping, the iteration (x*x, y*y, x*y, update) and the colour polynomials;
//   the 17-step divider gives count/limit and 14 steps compute the colour.
// Reset: synchronous; returns to idle and loads the default register values.
module julia_escape_time_pixel (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  jet_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output jet_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [jet_pkg::CSR_W-1:0]    csr_index,
   input  logic [jet_pkg::Q_W-1:0]      csr_data
);
   import jet_pkg::*;

   state_type                 state_ff, state_in;
   color_step_type            step_ff, step_in;

   logic [LIM_W-1:0]          limit_ff, limit_in;
   logic signed [Q_W-1:0]     half_w_ff, half_w_in;
   logic signed [Q_W-1:0]     half_h_ff, half_h_in;
   logic signed [Q_W-1:0]     c_re_ff, c_re_in;
   logic signed [Q_W-1:0]     c_im_ff, c_im_in;
   logic [BRIGHT_W-1:0]       bright_ff, bright_in;

   logic [POS_W-1:0]          row_ff, row_in;
   logic [POS_W-1:0]          col_ff, col_in;
   logic signed [Q_W-1:0]     x_ff, x_in;
   logic signed [Q_W-1:0]     y_ff, y_in;
   logic signed [PROD_W-1:0]  xx_ff, xx_in;
   logic signed [PROD_W-1:0]  yy_ff, yy_in;
   logic [LIM_W-1:0]          count_ff, count_in;
   logic [T_W-1:0]            t_ff, t_in;
   logic [T_W-1:0]            t2_ff, t2_in;
   logic [T_W-1:0]            u2_ff, u2_in;
   logic [COLOR_W-1:0]        red_ff, red_in;
   logic [COLOR_W-1:0]        green_ff, green_in;
   logic [COLOR_W-1:0]        blue_ff, blue_in;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  mul_prod;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   logic [T_W-1:0]            u_val;
   logic [T_W-1:0]            prod_hi;
   logic signed [PROD_W-1:0]  hw_ext, hh_ext, cr_ext, ci_ext;
   logic signed [PROD_W-1:0]  map_x_sum, map_y_sum;
   logic signed [PROD_W-1:0]  diff, xy2, re_sum, im_sum;
   logic [PROD_W-1:0]         esc_sum;
   logic                      it_done;
   logic [COLOR_W-1:0]        sat_28, sat_29;

   jet_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   jet_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign u_val   = T_ONE - t_ff;
   assign prod_hi = mul_prod[2*LIM_W:LIM_W];

   assign hw_ext = $signed({{(PROD_W-Q_W){half_w_ff[Q_W-1]}}, half_w_ff});
   assign hh_ext = $signed({{(PROD_W-Q_W){half_h_ff[Q_W-1]}}, half_h_ff});
   assign cr_ext = $signed({{(PROD_W-Q_W){c_re_ff[Q_W-1]}}, c_re_ff});
   assign ci_ext = $signed({{(PROD_W-Q_W){c_im_ff[Q_W-1]}}, c_im_ff});

   assign map_x_sum = mul_prod / ROWS_DIV - hw_ext;
   assign map_y_sum = mul_prod / COLS_DIV - hh_ext;
   assign diff      = xx_ff - yy_ff;
   assign xy2       = mul_prod <<< 1;
   assign re_sum    = (diff >>> FRAC) + cr_ext;
   assign im_sum    = (xy2 >>> FRAC) + ci_ext;

   assign esc_sum = xx_ff + mul_prod;
   assign it_done = (|esc_sum[PROD_W-1:ESC_SHIFT]) || (count_ff >= limit_ff);

   assign sat_28 = (|mul_prod[PROD_W-1:FRAC+COLOR_W]) ? '1 : mul_prod[FRAC+COLOR_W-1:FRAC];
   assign sat_29 = (|mul_prod[PROD_W-1:FRAC+COLOR_W+1]) ? '1 :
                   mul_prod[FRAC+COLOR_W:FRAC+1];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MAP_X;
            end
         end
         ST_MAP_X:    state_in = ST_MAP_Y;
         ST_MAP_Y:    state_in = ST_MAP_DONE;
         ST_MAP_DONE: state_in = ST_IT_XX;
         ST_IT_XX:    state_in = ST_IT_YY;
         ST_IT_YY:    state_in = ST_IT_XY;
         ST_IT_XY: begin
            state_in = it_done ? ST_DIV_START : ST_IT_UPD;
         end
         ST_IT_UPD:   state_in = ST_IT_XX;
         ST_DIV_START: begin
            state_in = (limit_ff == '0) ? ST_COLOR : ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_COLOR;
            end
         end
         ST_COLOR: begin
            if (step_ff == CS_BLUE) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // handshake, multiplier operands and divider start
   always_comb begin
      req_stall        = (state_ff != ST_IDLE);
      rsp_valid        = (state_ff == ST_OUT);
      div_req.start    = (state_ff == ST_DIV_START) && (limit_ff != '0);
      div_req.dividend = count_ff;
      div_req.divisor  = limit_ff;
      mul_a            = '0;
      mul_b            = '0;
      case (state_ff)
         ST_MAP_X: begin
            mul_a = {{(MUL_W-POS_W-1){1'b0}}, row_ff, 1'b0};
            mul_b = {half_w_ff[Q_W-1], half_w_ff};
         end
         ST_MAP_Y: begin
            mul_a = {{(MUL_W-POS_W-1){1'b0}}, col_ff, 1'b0};
            mul_b = {half_h_ff[Q_W-1], half_h_ff};
         end
         ST_IT_XX: begin
            mul_a = {x_ff[Q_W-1], x_ff};
            mul_b = {x_ff[Q_W-1], x_ff};
         end
         ST_IT_YY: begin
            mul_a = {y_ff[Q_W-1], y_ff};
            mul_b = {y_ff[Q_W-1], y_ff};
         end
         ST_IT_XY: begin
            mul_a = {x_ff[Q_W-1], x_ff};
            mul_b = {y_ff[Q_W-1], y_ff};
         end
         ST_COLOR: begin
            case (step_ff)
               CS_TT: begin
                  mul_a = {{(MUL_W-T_W){1'b0}}, t_ff};
                  mul_b = {{(MUL_W-T_W){1'b0}}, t_ff};
               end
               CS_UU: begin
                  mul_a = {{(MUL_W-T_W){1'b0}}, u_val};
                  mul_b = {{(MUL_W-T_W){1'b0}}, u_val};
               end
               CS_T2T: begin
                  mul_a = {{(MUL_W-T_W){1'b0}}, t2_ff};
                  mul_b = {{(MUL_W-T_W){1'b0}}, t_ff};
               end
               CS_T3U: begin
                  mul_a = {{(MUL_W-T_W){1'b0}}, prod_hi};
                  mul_b = {{(MUL_W-T_W){1'b0}}, u_val};
               end
               CS_RK: begin
                  mul_a = {{(MUL_W-T_W){1'b0}}, prod_hi};
                  mul_b = {{(MUL_W-16){1'b0}}, K_RED};
               end
               CS_RB, CS_GB, CS_BB: begin
                  mul_a = {1'b0, mul_prod[Q_W-1:0]};
                  mul_b = {{(MUL_W-BRIGHT_W){1'b0}}, bright_ff};
               end
               CS_U2T2: begin
                  mul_a = {{(MUL_W-T_W){1'b0}}, u2_ff};
                  mul_b = {{(MUL_W-T_W){1'b0}}, t2_ff};
               end
               CS_GK: begin
                  mul_a = {{(MUL_W-T_W){1'b0}}, prod_hi};
                  mul_b = {{(MUL_W-16){1'b0}}, K_GREEN};
               end
               CS_U2U: begin
                  mul_a = {{(MUL_W-T_W){1'b0}}, u2_ff};
                  mul_b = {{(MUL_W-T_W){1'b0}}, u_val};
               end
               CS_U3T: begin
                  mul_a = {{(MUL_W-T_W){1'b0}}, prod_hi};
                  mul_b = {{(MUL_W-T_W){1'b0}}, t_ff};
               end
               CS_BK: begin
                  mul_a = {{(MUL_W-T_W){1'b0}}, prod_hi};
                  mul_b = {{(MUL_W-16){1'b0}}, K_BLUE};
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // datapath and register file
   always_comb begin
      limit_in  = limit_ff;
      half_w_in = half_w_ff;
      half_h_in = half_h_ff;
      c_re_in   = c_re_ff;
      c_im_in   = c_im_ff;
      bright_in = bright_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      xx_in     = xx_ff;
      yy_in     = yy_ff;
      count_in  = count_ff;
      t_in      = t_ff;
      t2_in     = t2_ff;
      u2_in     = u2_ff;
      step_in   = step_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ITERATION_LIMIT:  limit_in  = csr_data[LIM_W-1:0];
            CSR_VIEW_HALF_WIDTH:  half_w_in = csr_data;
            CSR_VIEW_HALF_HEIGHT: half_h_in = csr_data;
            CSR_C_REAL:           c_re_in   = csr_data;
            CSR_C_IMAG:           c_im_in   = csr_data;
            CSR_BRIGHTNESS:       bright_in = csr_data[BRIGHT_W-1:0];
            default:              limit_in  = limit_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            row_in = req_data.pixel_row;
            col_in = req_data.pixel_col;
         end
         ST_MAP_Y: begin
            x_in = sat_q(map_x_sum);
         end
         ST_MAP_DONE: begin
            y_in     = sat_q(map_y_sum);
            count_in = '0;
         end
         ST_IT_YY: begin
            xx_in = mul_prod;
         end
         ST_IT_XY: begin
            yy_in = mul_prod;
         end
         ST_IT_UPD: begin
            x_in     = sat_q(re_sum);
            y_in     = sat_q(im_sum);
            count_in = count_ff + LIM_W'(1);
         end
         ST_DIV_START: begin
            t_in    = '0;
            step_in = CS_TT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               t_in = div_rsp.quotient;
            end
         end
         ST_COLOR: begin
            if (step_ff != CS_BLUE) begin
               step_in = color_step_type'(step_ff + 4'd1);
            end
            case (step_ff)
               CS_UU:   t2_in    = prod_hi;
               CS_T2T:  u2_in    = prod_hi;
               CS_U2T2: red_in   = sat_28;
               CS_U2U:  green_in = sat_28;
               CS_BLUE: blue_in  = sat_29;
               default: t2_in    = t2_ff;
            endcase
         end
         default: begin
            row_in = row_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         limit_ff  <= RST_LIMIT;
         half_w_ff <= RST_HALF;
         half_h_ff <= RST_HALF;
         c_re_ff   <= '0;
         c_im_ff   <= '0;
         bright_ff <= RST_BRIGHT;
      end else begin
         state_ff  <= state_in;
         limit_ff  <= limit_in;
         half_w_ff <= half_w_in;
         half_h_ff <= half_h_in;
         c_re_ff   <= c_re_in;
         c_im_ff   <= c_im_in;
         bright_ff <= bright_in;
      end
      step_ff  <= step_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      xx_ff    <= xx_in;
      yy_ff    <= yy_in;
      count_ff <= count_in;
      t_ff     <= t_in;
      t2_ff    <= t2_in;
      u2_ff    <= u2_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign csr_ready = 1'b1;

   assign rsp_data.red          = red_ff;
   assign rsp_data.green        = green_ff;
   assign rsp_data.blue         = blue_ff;
   assign rsp_data.escape_count = count_ff;

endmodule

@@ rtl/core/jet_checker.sv @@
// Port-level checks for julia_escape_time_pixel, attached by bind.
// Depends on jet_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jet_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input jet_pkg::rsp_type  rsp_data
);
   import jet_pkg::*;

   `JET_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result word dropped while stalled")
   `JET_ASSERT_RST(a_busy_out, clock, reset, rsp_valid |-> req_stall, "request taken while a result is pending")
   `JET_ASSERT_RST(a_one_pixel, clock, reset, req_valid && !req_stall |=> req_stall, "second request taken during a pixel")
   `JET_ASSERT_RST(a_zero_black, clock, reset, rsp_valid && rsp_data.escape_count == '0 |-> rsp_data.red == '0 && rsp_data.green == '0 && rsp_data.blue == '0, "colour on zero count")
   `JET_ASSERT_ALL(a_reset_idle, clock, reset |=> !req_stall && !rsp_valid, "not idle after reset")

endmodule

bind julia_escape_time_pixel jet_checker u_jet_checker (.*);
